// File: hdl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared widths, role and error codes, parser state and result types.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int BLOCK_COUNT_BITS = 16;
	localparam int MAX_BYTES_BITS   = 16;
	localparam int CMP_BITS = (BLOCK_COUNT_BITS > MAX_BYTES_BITS) ?
		BLOCK_COUNT_BITS : MAX_BYTES_BITS;

	localparam logic [3:0] ROLE_METHOD     = 4'd0;
	localparam logic [3:0] ROLE_SEP        = 4'd1;
	localparam logic [3:0] ROLE_RESOURCE   = 4'd2;
	localparam logic [3:0] ROLE_QUERY_MARK = 4'd3;
	localparam logic [3:0] ROLE_QUERY      = 4'd4;
	localparam logic [3:0] ROLE_VERSION    = 4'd5;
	localparam logic [3:0] ROLE_HEADER     = 4'd6;
	localparam logic [3:0] ROLE_LINE_END   = 4'd7;
	localparam logic [3:0] ROLE_BLOCK_END  = 4'd8;
	localparam logic [3:0] ROLE_IGNORED    = 4'd9;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

	localparam logic [1:0] MTH_NONE    = 2'd0;
	localparam logic [1:0] MTH_GET     = 2'd1;
	localparam logic [1:0] MTH_POST    = 2'd2;
	localparam logic [1:0] MTH_OPTIONS = 2'd3;

	localparam logic [0:0] KIND_DATA    = 1'b0;
	localparam logic [0:0] KIND_RESTART = 1'b1;

	localparam logic [3:0] PH_METHOD = 4'd0;

	typedef struct packed {
		logic [3:0]                  phase;
		logic [3:0]                  method_len;
		logic [2:0]                  method_match;
		logic [1:0]                  method_reg;
		logic [1:0]                  line_len;
		logic [BLOCK_COUNT_BITS-1:0] block_count;
		logic [1:0]                  version_index;
		logic                        version_reg;
		logic [1:0]                  error_reg;
		logic [7:0]                  header_count;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [3:0] role;
		logic [1:0] method_code;
		logic       version_is_10;
		logic [1:0] error_code;
		logic       block_done;
		logic [7:0] header_lines;
	} parse_result_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase:         PH_METHOD,
		method_len:    4'd0,
		method_match:  3'b111,
		method_reg:    MTH_NONE,
		line_len:      2'd0,
		block_count:   '0,
		version_index: 2'd0,
		version_reg:   1'b0,
		error_reg:     ERR_NONE,
		header_count:  8'd0
	};

	localparam logic [MAX_BYTES_BITS-1:0] MAX_BYTES_RESET = 16'd4096;

endpackage

// File: hdl/http_request_header_parser_core.sv
// ----------------------------------------------------------------------------
// HTTP request header parser core
// Splits a request byte stream into lines, parses the request line and tags
// every byte with its role, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  in        sink       in_valid/in_stall  kind, data_byte
//  out       source     out_valid/out_stall byte_out, role, method_code,
//                                          version_is_10, error_code,
//                                          block_done, header_lines
//  cfg       sink       cfg_valid/cfg_ready cfg_data (max_header_bytes)
//
// A request passes an input register and then a result register, from which
// its result is shown. One request is taken every cycle while the output
// is not stalled.
// The parser state updates in the cycle a request moves into the result register.
// Reset clears the parser state and sets max_header_bytes to 4096.
// A stalled output holds its result; the input stalls only while both
// registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module http_request_header_parser_core
	import hrhp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic [3:0]                role,
	output logic [1:0]                method_code,
	output logic                      version_is_10,
	output logic [1:0]                error_code,
	output logic                      block_done,
	output logic [7:0]                header_lines,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [MAX_BYTES_BITS-1:0] cfg_data
);

	parse_state_t              state_q;
	parse_state_t              state_nxt;
	parse_result_t             res_nxt;
	parse_result_t             res_s2;
	logic [MAX_BYTES_BITS-1:0] max_bytes_q;
	logic                      valid_s1;
	logic                      kind_s1;
	logic [7:0]                byte_s1;
	logic                      valid_s2;
	logic                      advance;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	hrhp_step u_step (
		.st               (state_q),
		.max_header_bytes (max_bytes_q),
		.kind             (kind_s1),
		.data_byte        (byte_s1),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_bytes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_CLEAR;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign byte_out      = res_s2.byte_out;
	assign role          = res_s2.role;
	assign method_code   = res_s2.method_code;
	assign version_is_10 = res_s2.version_is_10;
	assign error_code    = res_s2.error_code;
	assign block_done    = res_s2.block_done;
	assign header_lines  = res_s2.header_lines;

endmodule

// File: hdl/hrhp_step.sv
// ----------------------------------------------------------------------------
// HTTP request header parser step logic
// Computes the next parser state and the result for one request.
// ----------------------------------------------------------------------------
module hrhp_step
	import hrhp_pkg::*;
(
	input  parse_state_t                st,
	input  logic [MAX_BYTES_BITS-1:0]   max_header_bytes,
	input  logic                        kind,
	input  logic [7:0]                  data_byte,
	output parse_state_t                nxt,
	output parse_result_t               res
);

	localparam logic [3:0] PH_RESOURCE = 4'd1;
	localparam logic [3:0] PH_QUERY    = 4'd2;
	localparam logic [3:0] PH_VSEARCH  = 4'd3;
	localparam logic [3:0] PH_VCHECK   = 4'd4;
	localparam logic [3:0] PH_VREST    = 4'd5;
	localparam logic [3:0] PH_HEADERS  = 4'd6;
	localparam logic [3:0] PH_DONE     = 4'd7;
	localparam logic [3:0] PH_ERROR    = 4'd8;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	function automatic logic [7:0] get_char(input logic [1:0] pos);
		case (pos)
			2'd0:    get_char = 8'h47;
			2'd1:    get_char = 8'h45;
			2'd2:    get_char = 8'h54;
			default: get_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] post_char(input logic [1:0] pos);
		case (pos)
			2'd0:    post_char = 8'h50;
			2'd1:    post_char = 8'h4F;
			2'd2:    post_char = 8'h53;
			default: post_char = 8'h54;
		endcase
	endfunction

	function automatic logic [7:0] opt_char(input logic [2:0] pos);
		case (pos)
			3'd0:    opt_char = 8'h4F;
			3'd1:    opt_char = 8'h50;
			3'd2:    opt_char = 8'h54;
			3'd3:    opt_char = 8'h49;
			3'd4:    opt_char = 8'h4F;
			3'd5:    opt_char = 8'h4E;
			3'd6:    opt_char = 8'h53;
			default: opt_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] v10_char(input logic [1:0] pos);
		case (pos)
			2'd0:    v10_char = 8'h31;
			2'd1:    v10_char = 8'h2E;
			2'd2:    v10_char = 8'h30;
			default: v10_char = 8'h00;
		endcase
	endfunction

	logic [BLOCK_COUNT_BITS-1:0] count_inc;
	logic                        overflow;
	logic [2:0]                  match_nxt;
	logic [1:0]                  method_end;
	logic [3:0]                  role;

	always_comb begin
		count_inc = (st.block_count != '1) ? st.block_count + 1'b1 : st.block_count;
		overflow  = CMP_BITS'(count_inc) > CMP_BITS'(max_header_bytes);

		match_nxt = st.method_match;
		if (!(st.method_len < 4'd3 && get_char(st.method_len[1:0]) == data_byte)) begin
			match_nxt[0] = 1'b0;
		end
		if (!(st.method_len < 4'd4 && post_char(st.method_len[1:0]) == data_byte)) begin
			match_nxt[1] = 1'b0;
		end
		if (!(st.method_len < 4'd7 && opt_char(st.method_len[2:0]) == data_byte)) begin
			match_nxt[2] = 1'b0;
		end

		if (st.method_match[0] && st.method_len == 4'd3) begin
			method_end = MTH_GET;
		end else if (st.method_match[1] && st.method_len == 4'd4) begin
			method_end = MTH_POST;
		end else if (st.method_match[2] && st.method_len == 4'd7) begin
			method_end = MTH_OPTIONS;
		end else begin
			method_end = MTH_NONE;
		end

		nxt = st;
		role = ROLE_IGNORED;
		res.block_done = 1'b0;

		if (kind == KIND_RESTART) begin
			nxt = STATE_CLEAR;
		end else if (st.phase != PH_DONE && st.phase != PH_ERROR) begin
			nxt.block_count = count_inc;
			if (overflow) begin
				nxt.error_reg = ERR_TOO_LONG;
				nxt.phase = PH_ERROR;
			end else if (data_byte == CH_NL) begin
				role = ROLE_LINE_END;
				nxt.line_len = 2'd0;
				if (st.line_len < 2'd2) begin
					nxt.phase = PH_DONE;
					role = ROLE_BLOCK_END;
					res.block_done = 1'b1;
				end else if (st.phase == PH_HEADERS) begin
					if (st.header_count != 8'hFF) begin
						nxt.header_count = st.header_count + 8'd1;
					end
				end else if (st.phase == PH_VCHECK || st.phase == PH_VREST) begin
					nxt.phase = PH_HEADERS;
				end else begin
					nxt.error_reg = ERR_MALFORMED;
					nxt.phase = PH_ERROR;
				end
			end else begin
				if (st.line_len < 2'd2) begin
					nxt.line_len = st.line_len + 2'd1;
				end
				case (st.phase)
					PH_METHOD: begin
						if (data_byte == CH_SPACE) begin
							nxt.method_reg = method_end;
							nxt.phase = PH_RESOURCE;
							role = ROLE_SEP;
						end else begin
							nxt.method_match = match_nxt;
							if (st.method_len != 4'd15) begin
								nxt.method_len = st.method_len + 4'd1;
							end
							role = ROLE_METHOD;
						end
					end
					PH_RESOURCE: begin
						if (data_byte == CH_SPACE) begin
							nxt.phase = PH_VSEARCH;
							role = ROLE_SEP;
						end else if (data_byte == CH_QMARK) begin
							nxt.phase = PH_QUERY;
							role = ROLE_QUERY_MARK;
						end else begin
							role = ROLE_RESOURCE;
						end
					end
					PH_QUERY: begin
						if (data_byte == CH_SPACE) begin
							nxt.phase = PH_VSEARCH;
							role = ROLE_SEP;
						end else begin
							role = ROLE_QUERY;
						end
					end
					PH_VSEARCH: begin
						if (data_byte == CH_SLASH) begin
							nxt.phase = PH_VCHECK;
							nxt.version_index = 2'd0;
						end
						role = ROLE_VERSION;
					end
					PH_VCHECK: begin
						if (st.version_index < 2'd3 &&
								data_byte == v10_char(st.version_index)) begin
							nxt.version_index = st.version_index + 2'd1;
							if (st.version_index == 2'd2) begin
								nxt.version_reg = 1'b1;
								nxt.phase = PH_VREST;
							end
						end else begin
							nxt.phase = PH_VREST;
						end
						role = ROLE_VERSION;
					end
					PH_VREST: begin
						role = ROLE_VERSION;
					end
					default: begin
						role = ROLE_HEADER;
					end
				endcase
			end
		end

		res.byte_out      = (kind == KIND_RESTART) ? 8'h00 : data_byte;
		res.role          = role;
		res.method_code   = nxt.method_reg;
		res.version_is_10 = nxt.version_reg;
		res.error_code    = nxt.error_reg;
		res.header_lines  = nxt.header_count;
	end

endmodule

// File: hdl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// HTTP request header parser checker
// Port-level properties of the parser core, bound to the top level.
// ----------------------------------------------------------------------------
module hrhp_checker
	import hrhp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] byte_out,
	input logic [3:0] role,
	input logic [1:0] error_code,
	input logic       block_done
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(role))
		else $error("Stalled result changed.");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_done |->
			role == ROLE_BLOCK_END && byte_out == 8'h0A && error_code == ERR_NONE)
		else $error("Block end flagged on a request other than a clean newline.");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && role == ROLE_HEADER |-> error_code == ERR_NONE)
		else $error("Header byte tagged while an error is held.");

	a_qmark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && role == ROLE_QUERY_MARK |-> byte_out == 8'h3F)
		else $error("Query mark role on a byte other than a question mark.");

endmodule

bind http_request_header_parser_core hrhp_checker u_hrhp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.byte_out   (byte_out),
	.role       (role),
	.error_code (error_code),
	.block_done (block_done)
);
